### src/mono_framebuffer_line_rect_draw_defines.svh
// Assertion helpers for the frame buffer drawing block.
`ifndef MONO_FRAMEBUFFER_LINE_RECT_DRAW_DEFINES_SVH
`define MONO_FRAMEBUFFER_LINE_RECT_DRAW_DEFINES_SVH

// Check that an implication holds at every clock edge out of reset.
`define MFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a next-cycle implication holds out of reset.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mfb_pkg.sv
package mfb_pkg;
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int COORD_W = 7;
    localparam int ADDR_W  = 10;

    localparam logic [2:0] ACT_SET   = 3'd0;
    localparam logic [2:0] ACT_CLEAR = 3'd1;
    localparam logic [2:0] ACT_LINE  = 3'd2;
    localparam logic [2:0] ACT_RECT  = 3'd3;
    localparam logic [2:0] ACT_FILL  = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    localparam logic [1:0] ORIENT_CW  = 2'd1;
    localparam logic [1:0] ORIENT_CCW = 2'd2;
endpackage

### src/mfb_ram.sv
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/mono_framebuffer_line_rect_draw.sv
// Monochrome page frame buffer with drawing commands.
// Input: one command beat on s_axis_* (action, two points, pixel value,
// fill pattern, byte index). Output: one result beat on m_axis_* per command,
// read_data in bits 7:0 (zero except for read byte), done flag in bit 8.
// Orientation is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this. One command
// runs at a time. Every buffer pixel update is a read-modify-write through
// the single RAM port pair: the plot step issues the read, the write step
// writes the modified byte back. A reversed rectangle and unused actions go
// straight to done; fill buffer writes the pattern to every byte; read byte
// reads, then captures the byte. The block returns to idle for the next
// command as the result is loaded into the output register.
// After reset the block sweeps zeros through the whole buffer (1024 bytes at
// the default size) and holds s_axis_tready low meanwhile.
// When the receiver stalls, the result holds in the output register; the
// next command may be taken and run, but it waits in its final cycle until
// the register frees.
`include "mono_framebuffer_line_rect_draw_defines.svh"
module mono_framebuffer_line_rect_draw #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], x_first[9:3], y_first[16:10], x_second[23:17],
    // y_second[30:24], pixel_value[31], pattern[39:32], byte_index[49:40]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], done_res[8]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data
);
    import mfb_pkg::*;

    localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
    localparam int RAM_AW   = $clog2(FB_BYTES);
    localparam int CW       = COORD_W + 3;   // signed cursor width

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PLOT  = 4'd2;  // compute address, issue read
    localparam logic [3:0] ST_WRITE = 4'd3;  // modify and write back
    localparam logic [3:0] ST_FILL  = 4'd4;
    localparam logic [3:0] ST_RDW   = 4'd5;
    localparam logic [3:0] ST_RDD   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [1:0] orient_reg;
    logic [2:0] act_reg;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0] x1_reg, x2_reg, y2_reg;
    logic signed [CW+1:0] err_reg, err_next, dx_reg, dy_reg;
    logic sx_neg_reg, sy_neg_reg, xmaj_reg;
    logic val_reg;
    logic [7:0] pat_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [RAM_AW:0] faddr_reg, faddr_next;
    logic last_reg, last_next;     // current pixel is the final one
    logic hit_reg, hit_next;       // current pixel lands in the buffer
    logic [RAM_AW-1:0] paddr_reg, paddr_next;
    logic [2:0] pbit_reg, pbit_next;
    logic [7:0] rd_reg, rd_next;
    logic out_v_reg;
    logic [7:0] out_rd_reg;
    logic done_fire;

    logic ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    mfb_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [2:0] in_act;
    logic [COORD_W-1:0] in_xa, in_ya, in_xb, in_yb;
    assign in_act = s_axis_tdata[2:0];
    assign in_xa  = s_axis_tdata[9:3];
    assign in_ya  = s_axis_tdata[16:10];
    assign in_xb  = s_axis_tdata[23:17];
    assign in_yb  = s_axis_tdata[30:24];

    assign s_axis_tready = (state_reg == ST_IDLE);
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // finish a command only when the output register is free
    assign done_fire = (state_reg == ST_DONE) && (!out_v_reg || m_axis_tready);

    // address of the current cursor after orientation swap
    logic signed [CW-1:0] col, row;
    logic in_buf;
    logic [31:0] caddr_full;
    logic [RAM_AW-1:0] caddr;
    always_comb begin
        col = cx_reg;
        row = cy_reg;
        if (orient_reg == ORIENT_CW || orient_reg == ORIENT_CCW) begin
            col = cy_reg;
            row = cx_reg;
        end
        caddr_full = ({{(35-CW){1'b0}}, row[CW-1:3]} * 32'(SCREEN_WIDTH))
            + {{(32-CW){1'b0}}, col};
        in_buf = (col >= 0) && (row >= 0) && (col < CW'(SCREEN_WIDTH))
            && (row < CW'(SCREEN_HEIGHT)) && (caddr_full < 32'(FB_BYTES));
        caddr = caddr_full[RAM_AW-1:0];
    end

    logic signed [CW+1:0] dxi, dyi;
    always_comb begin
        dxi = (CW+2)'($signed({1'b0, in_xb})) - (CW+2)'($signed({1'b0, in_xa}));
        dyi = (CW+2)'($signed({1'b0, in_yb})) - (CW+2)'($signed({1'b0, in_ya}));
    end

    // next cursor for line and rectangle stepping
    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        err_next = err_reg;
        last_next = 1'b0;
        if (act_reg == ACT_LINE) begin
            if (xmaj_reg) begin
                cx_next = sx_neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                if (err_reg < 0) begin
                    err_next = err_reg + (dy_reg <<< 1);
                end else begin
                    err_next = err_reg + (dy_reg <<< 1) - (dx_reg <<< 1);
                    cy_next = sy_neg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                end
                last_next = (cx_next == x2_reg);
            end else begin
                cy_next = sy_neg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                if (err_reg < 0) begin
                    err_next = err_reg + (dx_reg <<< 1);
                end else begin
                    err_next = err_reg + (dx_reg <<< 1) - (dy_reg <<< 1);
                    cx_next = sx_neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                end
                last_next = (cy_next == y2_reg);
            end
        end else begin
            if (cx_reg == x2_reg) begin
                cx_next = x1_reg;
                cy_next = cy_reg + 1'b1;
            end else begin
                cx_next = cx_reg + 1'b1;
            end
            last_next = (cx_next == x2_reg) && (cy_next == y2_reg);
        end
    end

    logic [7:0] mod_byte;
    logic on_bit;
    assign on_bit = (act_reg == ACT_SET) || (act_reg == ACT_LINE)
        || ((act_reg == ACT_RECT) && val_reg);
    always_comb begin
        mod_byte = ram_rdata;
        mod_byte[pbit_reg] = on_bit;
    end

    always_comb begin
        state_next = state_reg;
        faddr_next = faddr_reg;
        ram_we = 1'b0;
        ram_waddr = faddr_reg[RAM_AW-1:0];
        ram_wdata = 8'd0;
        ram_raddr = caddr;
        paddr_next = paddr_reg;
        pbit_next = pbit_reg;
        hit_next = hit_reg;
        rd_next = rd_reg;
        case (state_reg)
            ST_CLR: begin
                ram_we = 1'b1;
                faddr_next = faddr_reg + 1'b1;
                if (faddr_reg == (RAM_AW+1)'(FB_BYTES - 1)) begin
                    faddr_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    rd_next = 8'd0;
                    case (in_act)
                        ACT_SET, ACT_CLEAR, ACT_LINE: state_next = ST_PLOT;
                        ACT_RECT: state_next = ((in_xa > in_xb) || (in_ya > in_yb))
                            ? ST_DONE : ST_PLOT;
                        ACT_FILL: state_next = ST_FILL;
                        ACT_READ: state_next = ST_RDW;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_PLOT: begin
                paddr_next = caddr;
                pbit_next = row[2:0];
                hit_next = in_buf;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                ram_we = hit_reg;
                ram_waddr = paddr_reg;
                ram_wdata = mod_byte;
                state_next = last_reg ? ST_DONE : ST_PLOT;
            end
            ST_FILL: begin
                ram_we = 1'b1;
                ram_wdata = pat_reg;
                faddr_next = faddr_reg + 1'b1;
                if (faddr_reg == (RAM_AW+1)'(FB_BYTES - 1)) begin
                    faddr_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_RDW: begin
                ram_raddr = RAM_AW'(idx_reg);
                state_next = ST_RDD;
            end
            ST_RDD: begin
                if ({{(ADDR_W){1'b0}}, idx_reg} < (ADDR_W+RAM_AW)'(FB_BYTES)) begin
                    rd_next = ram_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (done_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            orient_reg <= 2'd0;
            faddr_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            faddr_reg <= faddr_next;
            if (cfg_wr_en) begin
                orient_reg <= cfg_wr_data;
            end
            if (done_fire) begin
                out_v_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        paddr_reg <= paddr_next;
        pbit_reg <= pbit_next;
        hit_reg <= hit_next;
        rd_reg <= rd_next;
        if (done_fire) begin
            out_rd_reg <= rd_reg;
        end
        if (in_acc) begin
            act_reg <= in_act;
            x1_reg <= CW'(in_xa);
            x2_reg <= CW'(in_xb);
            y2_reg <= CW'(in_yb);
            cx_reg <= CW'(in_xa);
            cy_reg <= CW'(in_ya);
            val_reg <= s_axis_tdata[31];
            pat_reg <= s_axis_tdata[39:32];
            idx_reg <= s_axis_tdata[49:40];
            sx_neg_reg <= !(dxi > 0);
            sy_neg_reg <= !(dyi > 0);
            dx_reg <= (dxi < 0) ? -dxi : dxi;
            dy_reg <= (dyi < 0) ? -dyi : dyi;
            xmaj_reg <= ((dxi < 0) ? -dxi : dxi) >= ((dyi < 0) ? -dyi : dyi);
            if ((((dxi < 0) ? -dxi : dxi) >= ((dyi < 0) ? -dyi : dyi))) begin
                err_reg <= (((dyi < 0) ? -dyi : dyi) <<< 1) - ((dxi < 0) ? -dxi : dxi);
            end else begin
                err_reg <= (((dxi < 0) ? -dxi : dxi) <<< 1) - ((dyi < 0) ? -dyi : dyi);
            end
            // single pixel commands and degenerate shapes end on first pixel
            case (in_act)
                ACT_LINE: last_reg <= (((dxi < 0) ? -dxi : dxi) >= ((dyi < 0) ? -dyi : dyi))
                    ? (in_xa == in_xb) : (in_ya == in_yb);
                ACT_RECT: last_reg <= (in_xa == in_xb) && (in_ya == in_yb);
                default:  last_reg <= 1'b1;
            endcase
        end else if (state_reg == ST_WRITE) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            err_reg <= err_next;
            last_reg <= last_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {7'd0, 1'b1, out_rd_reg};

    `MFB_ASSERT_NEXT(a_hold_when_stalled, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
    `MFB_ASSERT_NEXT(a_done_gives_beat, aclk, aresetn, state_reg == ST_DONE, m_axis_tvalid, "finished command gave no result")
    `MFB_ASSERT_IMPL(a_write_only_working, aclk, aresetn, ram_we, state_reg == ST_CLR || state_reg == ST_FILL || state_reg == ST_WRITE, "buffer written outside a draw step")
endmodule
